[hdl/assert_macros.svh]
// Assertion shorthands used by the core checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define DES_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("DES core: invariant violated");

// Check a temporal property outside reset.
`define DES_ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("DES core: temporal property violated");

`endif

[hdl/des_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

	localparam int ROUNDS  = 16;
	// accept edge -> IP stage -> ROUNDS cells -> output register -> sampled strobe
	localparam int LATENCY = ROUNDS + 2;

	typedef logic [31:0] half_t;
	typedef logic [27:0] half_key_t;
	typedef logic [1:0]  rot_t;
	typedef logic [47:0] subkey_t;

	typedef struct packed {
		logic      valid;
		logic      mode;
		half_t     l;
		half_t     r;
		half_key_t c;
		half_key_t d;
	} stage_t;

	localparam logic [6:0] PC1_TAB [56] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
		7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
		7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [6:0] PC2_TAB [48] = '{
		7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
		7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
		7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
		7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
	};

	localparam logic [6:0] IP_TAB [64] = '{
		7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
		7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
		7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
	};

	localparam logic [6:0] FP_TAB [64] = '{
		7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
		7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
		7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
		7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
		7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
		7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
		7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
		7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
	};

	localparam logic [5:0] E_TAB [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
		6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
		6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
		6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
		6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam logic [5:0] P_TAB [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	// Left rotation before each round when encrypting.
	localparam rot_t ROT_ENC [ROUNDS] = '{
		2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
	};

	// Right rotation before each round when decrypting: the full schedule
	// turns 28 places, so the first decrypt round uses PC-1 output as is.
	localparam rot_t ROT_DEC [ROUNDS] = '{
		2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
	};

	localparam logic [3:0] SBOX_TAB [8][64] = '{
		'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		  4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
		  4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
		  4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
		  4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
		  4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
		  4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
		  4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
		'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
		  4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
		  4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
		  4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
		  4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
		  4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
		  4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
		  4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
		'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
		  4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
		  4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
		  4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
		  4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
		  4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
		  4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
		  4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
		'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
		  4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
		  4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
		  4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
		  4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
		  4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
		  4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
		  4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
		'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
		  4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
		  4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
		  4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
		  4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
		  4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
		  4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
		  4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
		'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
		  4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
		  4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
		  4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
		  4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
		  4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
		  4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
		  4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
		'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
		  4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
		  4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
		  4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
		  4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
		  4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
		  4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
		  4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
		'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
		  4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
		  4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
		  4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
		  4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
		  4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
		  4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
		  4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
	};

	// Table entries count bit positions from the MSB, starting at one.
	function automatic logic [55:0] pc1_perm(input logic [63:0] din);
		logic [55:0] dout;
		for (int i = 0; i < 56; i++) dout[55 - i] = din[64 - int'(PC1_TAB[i])];
		return dout;
	endfunction

	function automatic subkey_t pc2_perm(input logic [55:0] din);
		subkey_t dout;
		for (int i = 0; i < 48; i++) dout[47 - i] = din[56 - int'(PC2_TAB[i])];
		return dout;
	endfunction

	function automatic logic [63:0] ip_perm(input logic [63:0] din);
		logic [63:0] dout;
		for (int i = 0; i < 64; i++) dout[63 - i] = din[64 - int'(IP_TAB[i])];
		return dout;
	endfunction

	function automatic logic [63:0] fp_perm(input logic [63:0] din);
		logic [63:0] dout;
		for (int i = 0; i < 64; i++) dout[63 - i] = din[64 - int'(FP_TAB[i])];
		return dout;
	endfunction

	function automatic half_key_t rotl28(input half_key_t v, input rot_t s);
		half_key_t res;
		unique case (s)
			2'd1: res = {v[26:0], v[27]};
			2'd2: res = {v[25:0], v[27:26]};
			default: res = v;
		endcase
		return res;
	endfunction

	function automatic half_key_t rotr28(input half_key_t v, input rot_t s);
		half_key_t res;
		unique case (s)
			2'd1: res = {v[0], v[27:1]};
			2'd2: res = {v[1:0], v[27:2]};
			default: res = v;
		endcase
		return res;
	endfunction

	// Round function: expand, mix key, substitute, permute.
	function automatic half_t feistel(input half_t r, input subkey_t k);
		subkey_t x;
		half_t   s;
		half_t   dout;
		logic [5:0] b;
		for (int i = 0; i < 48; i++) x[47 - i] = r[32 - int'(E_TAB[i])];
		x = x ^ k;
		for (int i = 0; i < 8; i++) begin
			b = x[47 - 6 * i -: 6];
			s[31 - 4 * i -: 4] = SBOX_TAB[i][{b[5], b[0], b[4:1]}];
		end
		for (int i = 0; i < 32; i++) dout[31 - i] = s[32 - int'(P_TAB[i])];
		return dout;
	endfunction

endpackage

`default_nettype wire

[hdl/des_round_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module des_round_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  des_pkg::stage_t prev,
	input  des_pkg::rot_t   rot_enc,
	input  des_pkg::rot_t   rot_dec,
	output des_pkg::stage_t next
);
	import des_pkg::*;

	half_key_t c_rot;
	half_key_t d_rot;
	subkey_t   subkey;
	half_t     f_out;

	logic      valid_s1;
	logic      mode_s1;
	half_t     l_s1;
	half_t     r_s1;
	half_key_t c_s1;
	half_key_t d_s1;

	// Advance the key schedule one step, forward or backward by mode.
	always_comb begin
		if (prev.mode) begin
			c_rot = rotr28(prev.c, rot_dec);
			d_rot = rotr28(prev.d, rot_dec);
		end else begin
			c_rot = rotl28(prev.c, rot_enc);
			d_rot = rotl28(prev.d, rot_enc);
		end
		subkey = pc2_perm({c_rot, d_rot});
		f_out  = feistel(prev.r, subkey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= prev.valid;
		end
	end

	// Swap halves every round; the top level undoes the last one.
	always_ff @(posedge clk) begin
		mode_s1 <= prev.mode;
		l_s1    <= prev.r;
		r_s1    <= prev.l ^ f_out;
		c_s1    <= c_rot;
		d_s1    <= d_rot;
	end

	assign next = '{valid: valid_s1, mode: mode_s1, l: l_s1, r: r_s1, c: c_s1, d: d_s1};

endmodule

`default_nettype wire

[hdl/des_block_cipher_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// DES (ECB) engine, fully pipelined: one 64-bit word is taken on every clock
// at which start is high, and busy never rises, so the caller may issue a new
// word each cycle. The result comes back through one stage for the initial
// permutation, sixteen round cells (one per DES round, each carrying its own
// copy of the key schedule halves), and one output register for the final
// permutation. done is high for exactly one cycle with result_block alongside
// it; there is no way to hold a result off, so the receiver must take it in
// that cycle. Results leave in the order the words went in. mode selects
// encrypt (0) or decrypt (1) per word. key_word is loaded when key_we is high;
// change it only with no word in flight.
module des_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [63:0] data_block,
	input  logic        key_we,
	input  logic [63:0] key_word,
	output logic        done,
	output logic [63:0] result_block
);
	import des_pkg::*;

	logic [55:0] cd_q;      // key after PC-1, parity bits dropped
	logic        accept;

	logic        valid_s0;
	logic        mode_s0;
	logic [63:0] ip_s0;
	logic [55:0] cd_s0;

	stage_t      chain [ROUNDS + 1];

	logic        done_q;
	logic [63:0] result_q;

	// The pipeline takes a word every cycle; nothing ever stalls it.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Key register: hold PC-1 of the key so every word starts from it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q <= '0;
		end else if (key_we) begin
			cd_q <= pc1_perm(key_word);
		end
	end

	// Input stage: initial permutation and a snapshot of the key halves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		mode_s0 <= mode;
		ip_s0   <= ip_perm(data_block);
		cd_s0   <= cd_q;
	end

	assign chain[0] = '{
		valid: valid_s0,
		mode:  mode_s0,
		l:     ip_s0[63:32],
		r:     ip_s0[31:0],
		c:     cd_s0[55:28],
		d:     cd_s0[27:0]
	};

	// Round cells: each one does a full DES round and passes the word on.
	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		des_round_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prev    (chain[g]),
			.rot_enc (ROT_ENC[g]),
			.rot_dec (ROT_DEC[g]),
			.next    (chain[g + 1])
		);
	end

	// Output stage: drop the last swap (R16 L16) and apply the final permutation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= fp_perm({chain[ROUNDS].r, chain[ROUNDS].l});
	end

	assign done         = done_q;
	assign result_block = result_q;

endmodule

`default_nettype wire

[hdl/des_core_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module des_core_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import des_pkg::*;

	// The engine is fully pipelined and must never refuse a word.
	`DES_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)

	// Every accepted word comes back after the fixed pipeline depth.
	`DES_ASSERT_PROP(a_accept_to_done, clk, arst_n, (start && !busy) |-> ##LATENCY done)

	// No result strobe without a word accepted exactly that long ago.
	`DES_ASSERT_PROP(a_done_has_word, clk, arst_n, done |-> $past(start && !busy, LATENCY))

endmodule

bind des_block_cipher_core des_core_checker u_checker (.*);

`default_nettype wire
